@@ design/tiac_pkg.sv @@
// Shared types and constants for the telnet IAC option negotiator.
// Holds byte codes, parse phase codes, reply verb and echo change codes.
// Depends on nothing.
`default_nettype none

package tiac_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;

  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_DATA = 3'd0;
  localparam logic [PhaseW-1:0] PH_CMD  = 3'd1;
  localparam logic [PhaseW-1:0] PH_WILL = 3'd2;
  localparam logic [PhaseW-1:0] PH_WONT = 3'd3;
  localparam logic [PhaseW-1:0] PH_DO   = 3'd4;
  localparam logic [PhaseW-1:0] PH_DONT = 3'd5;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_DENY_ECHO        = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_OVERRIDE_REFUSAL = 1'd1;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_e;

  typedef enum logic [1:0] {
    ECHO_NONE   = 2'd0,
    ECHO_RAW    = 2'd1,
    ECHO_COOKED = 2'd2
  } echo_e;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_REPLY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] term_byte;
    verb_e      verb;
    logic [7:0] option;
    echo_e      echo;
  } result_t;

endpackage

`default_nettype wire

@@ design/telnet_iac_option_negotiator.sv @@
// Telnet receive-side IAC parser and client option negotiator.
// Input register, one pass of negotiation logic, result register.
// Depends on tiac_pkg.
//
//  channel | valid       | flow control | payload
//  --------+-------------+--------------+--------------------------------------
//  in      | in_valid_i  | in_stall_o   | rx_byte_i
//  out     | out_valid_o | out_stall_i  | kind_o term_byte_o reply_verb_o
//          |             |              | reply_option_o echo_change_o
//  cfg     | cfg_valid_i | cfg_ready_o  | cfg_index_i cfg_data_i
//
// One byte per clock sustained while out_stall_i is low; a byte is held in the
// input register and its result, if any, is then held in the result register.
// The parse phase and option flags update in the single negotiation pass.
// Reset clears phase, flags and configuration; cfg_ready_o is always high.
// A stalled result holds the result register; the input register then holds
// and in_stall_o rises once it is occupied.
`default_nettype none

module telnet_iac_option_negotiator import tiac_pkg::*; #(
  parameter int unsigned MAX_OPTION = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    kind_o,
  output logic [7:0]              term_byte_o,
  output logic [1:0]              reply_verb_o,
  output logic [7:0]              reply_option_o,
  output logic [1:0]              echo_change_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic               cfg_data_i
);

  localparam int unsigned NumOpt = MAX_OPTION + 1;
  localparam int unsigned IdxW   = (NumOpt > 1) ? $clog2(NumOpt) : 1;
  localparam logic [7:0]  MaxOpt = 8'(MAX_OPTION);
  localparam logic [IdxW-1:0] IdxEcho = IdxW'(OPT_ECHO);
  localparam logic [IdxW-1:0] IdxSga  = IdxW'(OPT_SGA);

  logic              deny_echo_q, override_refusal_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [NumOpt-1:0] remote_q, remote_d;
  logic [NumOpt-1:0] local_q, local_d;
  logic              out_valid_q;
  result_t           res_q, res_d;
  logic              res_valid;
  logic              advance;
  logic              in_range;
  logic [IdxW-1:0]   opt_idx;
  logic              refusing;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;

  assign in_range = (in_byte_q <= MaxOpt);
  assign opt_idx  = in_byte_q[IdxW-1:0];
  assign refusing = deny_echo_q && !override_refusal_q;

  always_comb begin
    phase_d   = PH_DATA;
    remote_d  = remote_q;
    local_d   = local_q;
    res_valid = 1'b0;
    res_d     = '{kind: KIND_REPLY, term_byte: 8'd0, verb: VERB_WILL,
                  option: in_byte_q, echo: ECHO_NONE};
    unique case (phase_q)
      PH_CMD: begin
        if (in_byte_q == B_IAC) begin
          res_valid      = 1'b1;
          res_d.kind     = KIND_DATA;
          res_d.term_byte = B_IAC;
          res_d.option   = 8'd0;
        end else if (in_byte_q == B_WILL) begin
          phase_d = PH_WILL;
        end else if (in_byte_q == B_WONT) begin
          phase_d = PH_WONT;
        end else if (in_byte_q == B_DO) begin
          phase_d = PH_DO;
        end else if (in_byte_q == B_DONT) begin
          phase_d = PH_DONT;
        end
      end
      PH_WILL: begin
        res_d.verb = VERB_DONT;
        priority if (in_byte_q != OPT_BINARY && in_byte_q != OPT_ECHO
                     && in_byte_q != OPT_SGA) begin
          res_valid = 1'b1;
        end else if (remote_q[opt_idx]) begin
          res_valid = 1'b0;
        end else if (in_byte_q == OPT_ECHO && refusing) begin
          res_valid = 1'b1;
        end else begin
          res_valid          = 1'b1;
          res_d.verb         = VERB_DO;
          remote_d[opt_idx]  = 1'b1;
          if (opt_idx == IdxEcho) begin
            res_d.echo = ECHO_RAW;
          end
        end
      end
      PH_WONT: begin
        res_d.verb = VERB_DONT;
        if (!in_range) begin
          res_valid = 1'b1;
        end else if (remote_q[opt_idx]) begin
          res_valid         = 1'b1;
          remote_d[opt_idx] = 1'b0;
          if (opt_idx == IdxEcho) begin
            res_d.echo = ECHO_COOKED;
          end
        end
      end
      PH_DO: begin
        if (in_byte_q != OPT_SGA) begin
          res_valid  = 1'b1;
          res_d.verb = VERB_WONT;
        end else if (!local_q[IdxSga]) begin
          res_valid       = 1'b1;
          res_d.verb      = VERB_WILL;
          local_d[IdxSga] = 1'b1;
        end
      end
      PH_DONT: begin
        res_d.verb = VERB_WONT;
        if (!in_range) begin
          res_valid = 1'b1;
        end else if (local_q[opt_idx]) begin
          res_valid        = 1'b1;
          local_d[opt_idx] = 1'b0;
        end
      end
      default: begin
        if (in_byte_q == B_IAC) begin
          phase_d = PH_CMD;
        end else begin
          res_valid       = 1'b1;
          res_d.kind      = KIND_DATA;
          res_d.term_byte = in_byte_q;
          res_d.option    = 8'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deny_echo_q        <= 1'b0;
      override_refusal_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DENY_ECHO:        deny_echo_q        <= cfg_data_i;
        CFG_OVERRIDE_REFUSAL: override_refusal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DATA;
      remote_q <= '0;
      local_q  <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      remote_q <= remote_d;
      local_q  <= local_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = res_q.kind;
  assign term_byte_o    = res_q.term_byte;
  assign reply_verb_o   = res_q.verb;
  assign reply_option_o = res_q.option;
  assign echo_change_o  = res_q.echo;

  a_data_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DATA |->
      reply_verb_o == VERB_WILL && reply_option_o == 8'd0 && echo_change_o == ECHO_NONE)
    else $error("data result carries reply fields");

  a_reply_no_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REPLY |-> term_byte_o == 8'd0)
    else $error("reply result carries a terminal byte");

  a_raw_only_on_echo_do: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && echo_change_o == ECHO_RAW |->
      reply_verb_o == VERB_DO && reply_option_o == OPT_ECHO)
    else $error("raw echo change without DO ECHO");

  a_flags_only_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !remote_q[2] && local_q == (local_q & (NumOpt'(1) << IdxSga)))
    else $error("option flag set for an unsupported option");

endmodule

`default_nettype wire

@@ sim/tb_telnet_iac_option_negotiator.sv @@
// Self-checking testbench for telnet_iac_option_negotiator.
// A scoreboard class predicts data bytes and negotiation replies per transfer.
// Depends on tiac_pkg and the negotiator RTL.
`timescale 1ns / 1ps

module tb_telnet_iac_option_negotiator;
  import tiac_pkg::*;

  localparam int MAX_OPT = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int BYTES_PER_PHASE = 225;
  localparam int HOLD_OFF_CYCLES = 80;

  class negotiation_scoreboard;
    logic deny_echo;
    logic override_refusal;
    logic [PhaseW-1:0] phase;
    bit remote_on [MAX_OPT+1];
    bit local_on [MAX_OPT+1];
    result_t awaited [$];
    int unsigned errors;
    int unsigned bytes_in;
    int unsigned data_seen;
    int unsigned replies_seen;

    function new();
      deny_echo = 1'b0;
      override_refusal = 1'b0;
      phase = PH_DATA;
      foreach (remote_on[i]) remote_on[i] = 1'b0;
      foreach (local_on[i]) local_on[i] = 1'b0;
      errors = 0;
      bytes_in = 0;
      data_seen = 0;
      replies_seen = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic val);
      case (idx)
        CFG_DENY_ECHO:        deny_echo = val;
        CFG_OVERRIDE_REFUSAL: override_refusal = val;
        default: ;
      endcase
    endfunction

    function void push_data(logic [7:0] b);
      result_t r;
      r.kind = KIND_DATA;
      r.term_byte = b;
      r.verb = VERB_WILL;
      r.option = 8'd0;
      r.echo = ECHO_NONE;
      awaited.push_back(r);
    endfunction

    function void push_reply(verb_e v, logic [7:0] opt, echo_e e);
      result_t r;
      r.kind = KIND_REPLY;
      r.term_byte = 8'd0;
      r.verb = v;
      r.option = opt;
      r.echo = e;
      awaited.push_back(r);
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [PhaseW-1:0] ph;
      ph = phase;
      phase = PH_DATA;
      bytes_in++;
      case (ph)
        PH_CMD: begin
          if (b == B_IAC) push_data(B_IAC);
          else if (b == B_WILL) phase = PH_WILL;
          else if (b == B_WONT) phase = PH_WONT;
          else if (b == B_DO) phase = PH_DO;
          else if (b == B_DONT) phase = PH_DONT;
        end
        PH_WILL: begin
          if (b != OPT_BINARY && b != OPT_ECHO && b != OPT_SGA) begin
            push_reply(VERB_DONT, b, ECHO_NONE);
          end else if (!remote_on[b]) begin
            if (b == OPT_ECHO && deny_echo && !override_refusal) begin
              push_reply(VERB_DONT, b, ECHO_NONE);
            end else begin
              remote_on[b] = 1'b1;
              push_reply(VERB_DO, b, (b == OPT_ECHO) ? ECHO_RAW : ECHO_NONE);
            end
          end
        end
        PH_WONT: begin
          if (b > MAX_OPT) begin
            push_reply(VERB_DONT, b, ECHO_NONE);
          end else if (remote_on[b]) begin
            remote_on[b] = 1'b0;
            push_reply(VERB_DONT, b, (b == OPT_ECHO) ? ECHO_COOKED : ECHO_NONE);
          end
        end
        PH_DO: begin
          if (b != OPT_SGA) begin
            push_reply(VERB_WONT, b, ECHO_NONE);
          end else if (!local_on[b]) begin
            local_on[b] = 1'b1;
            push_reply(VERB_WILL, b, ECHO_NONE);
          end
        end
        PH_DONT: begin
          if (b > MAX_OPT) begin
            push_reply(VERB_WONT, b, ECHO_NONE);
          end else if (local_on[b]) begin
            local_on[b] = 1'b0;
            push_reply(VERB_WONT, b, ECHO_NONE);
          end
        end
        default: begin
          if (b == B_IAC) phase = PH_CMD;
          else push_data(b);
        end
      endcase
    endfunction

    function void check_output(result_t act);
      result_t exp;
      if (awaited.size() == 0) begin
        $error("unexpected result: kind %0d term_byte %0d verb %0d option %0d echo %0d",
               act.kind, act.term_byte, act.verb, act.option, act.echo);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (act.kind == KIND_DATA) data_seen++;
      else replies_seen++;
      if (act.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, act.kind);
        errors++;
      end
      if (act.term_byte !== exp.term_byte) begin
        $error("term_byte: expected %0d, got %0d", exp.term_byte, act.term_byte);
        errors++;
      end
      if (act.verb !== exp.verb) begin
        $error("reply_verb: expected %0d, got %0d", exp.verb, act.verb);
        errors++;
      end
      if (act.option !== exp.option) begin
        $error("reply_option: expected %0d, got %0d", exp.option, act.option);
        errors++;
      end
      if (act.echo !== exp.echo) begin
        $error("echo_change: expected %0d, got %0d", exp.echo, act.echo);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_stall;
  logic kind;
  logic [7:0] term_byte;
  logic [1:0] reply_verb;
  logic [7:0] reply_option;
  logic [1:0] echo_change;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic cfg_data;

  negotiation_scoreboard sb;
  bit quiet;
  int hold_off_cnt;
  int unsigned cycle_count;

  telnet_iac_option_negotiator #(.MAX_OPTION(MAX_OPT)) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .term_byte_o    (term_byte),
    .reply_verb_o   (reply_verb),
    .reply_option_o (reply_option),
    .echo_change_o  (echo_change),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches and a counted hold-off
  always begin
    @(negedge clk);
    if (hold_off_cnt > 0) begin
      out_stall <= 1'b1;
      hold_off_cnt--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    result_t act;
    if (rst_n && out_valid && !out_stall) begin
      act.kind = kind_e'(kind);
      act.term_byte = term_byte;
      act.verb = verb_e'(reply_verb);
      act.option = reply_option;
      act.echo = echo_e'(echo_change);
      sb.check_output(act);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      rx_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_rx_byte(b);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] directed [$];
    logic [7:0] opt;
    int unsigned pick;
    int unsigned target;
    bit held;

    sb = new();
    quiet = 1'b0;
    hold_off_cnt = 0;
    cycle_count = 0;
    held = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    rx_byte = 8'd0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DENY_ECHO;
    cfg_data = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // plain bytes, escaped IAC, dropped command, then each verb's cases
    directed = '{8'h00, 8'hFE, B_IAC, B_IAC, B_IAC, 8'hF1,
                 B_IAC, B_WILL, OPT_ECHO, B_IAC, B_WILL, OPT_ECHO,
                 B_IAC, B_WONT, OPT_ECHO, B_IAC, B_DO, OPT_SGA,
                 B_IAC, B_DONT, OPT_SGA, B_IAC, B_WONT, 8'hFF,
                 B_IAC, B_DONT, 8'h07};
    foreach (directed[i]) send_byte(directed[i]);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_register(CFG_DENY_ECHO, (p == 1 || p == 2));
      write_register(CFG_OVERRIDE_REFUSAL, (p >= 2));
      quiet = (p == 2);
      target = sb.bytes_in + BYTES_PER_PHASE;
      while (sb.bytes_in < target) begin
        if (p == 0 && !held && sb.bytes_in + 120 >= target) begin
          hold_off_cnt = HOLD_OFF_CYCLES;
          held = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
          send_byte(8'($urandom_range(254)));
        end else if (pick < 85) begin
          case ($urandom_range(4))
            0: opt = OPT_BINARY;
            1: opt = OPT_ECHO;
            2: opt = OPT_SGA;
            3: opt = 8'($urandom_range(MAX_OPT + 1));
            default: opt = 8'($urandom_range(255));
          endcase
          send_byte(B_IAC);
          send_byte(B_WILL + 8'($urandom_range(3)));
          send_byte(opt);
        end else if (pick < 90) begin
          send_byte(B_IAC);
          send_byte(B_IAC);
        end else if (pick < 95) begin
          send_byte(B_IAC);
          send_byte(8'($urandom_range(250)));
        end else begin
          send_byte(8'($urandom_range(255)));
        end
      end
      drain();
    end
    quiet = 1'b0;

    if (sb.awaited.size() != 0) begin
      $error("%0d expected results never arrived", sb.awaited.size());
      sb.errors++;
    end
    $display("%0d bytes transferred in over four register settings", sb.bytes_in);
    $display("%0d data bytes and %0d negotiation replies checked",
             sb.data_seen, sb.replies_seen);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
